FILE: rtl/core/quaternion_to_euler_with_yaw_zero_macros.svh
// assertion macros for the quaternion to euler block
// used by quaternion_to_euler_with_yaw_zero.sv, expects clk and arst_n in scope
`ifndef QUATERNION_TO_EULER_WITH_YAW_ZERO_MACROS_SVH
`define QUATERNION_TO_EULER_WITH_YAW_ZERO_MACROS_SVH

// same-cycle implication
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/qte_pkg.sv
// shared constants and the cordic angle table for the quaternion to euler block
// no dependencies
package qte_pkg;

	localparam int QUAT_FRAC_BITS   = 14;
	localparam int ANGLE_FRAC_BITS  = 8;
	localparam int HEAD_FRAC_BITS   = 13;
	localparam int CORDIC_STEPS_DEF = 16;

	// cordic datapath width, covers pre-rotation and gain growth
	localparam int CORDIC_W = 37;
	// accumulator width for sums of two component products
	localparam int SUM_W    = 33;

	localparam logic signed [CORDIC_W-1:0] ONE_Q =
		CORDIC_W'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
	localparam logic signed [33:0] SIN_MAX = 34'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
	localparam int S30_SHIFT = 30 - 2 * QUAT_FRAC_BITS;

	localparam logic signed [31:0] DEG_PER_TURN    = 32'(360 << ANGLE_FRAC_BITS);
	localparam logic signed [31:0] RAD_PER_DEG_Q32 = 32'sd74961321;
	localparam int HEAD_SHIFT = 32 + ANGLE_FRAC_BITS - HEAD_FRAC_BITS;

	localparam logic signed [17:0] HALF_TURN    = 18'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [16:0] QUARTER_TURN = 17'(90 << ANGLE_FRAC_BITS);

	localparam logic [31:0] BAM_QUARTER  = 32'h4000_0000;
	localparam logic [31:0] BAM_NQUARTER = 32'hC000_0000;

	// atan(2^-i) in binary angle units, 2^32 per turn
	function automatic logic [31:0] atan_bam(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/quaternion_to_euler_with_yaw_zero.sv
// quaternion to roll, pitch, offset-corrected yaw and heading, with a zero-yaw event
// depends on qte_pkg and quaternion_to_euler_with_yaw_zero_macros.svh
//
// one item is in flight at a time. a sample passes through the shared multiplier for the
// component products, a square root for the pitch cosine, and three vectoring cordic
// runs on the one shift-add unit. a zero-yaw event goes straight to the output stage.
// in_stall is high from the transfer of an item until its result sits in the output
// register; the output register lets the next item in while a result waits
module quaternion_to_euler_with_yaw_zero
	import qte_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic signed [15:0] quat_real,
	input  logic signed [15:0] quat_i,
	input  logic signed [15:0] quat_j,
	input  logic signed [15:0] quat_k,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] roll_deg,
	output logic signed [15:0] pitch_deg,
	output logic signed [16:0] yaw_deg,
	output logic signed [15:0] heading_rad,
	output logic               from_zero_event
);

	// step count beyond the angle table behaves as the full table
	localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam logic [4:0] STEP_LAST = 5'(STEPS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_PROD, S_CLAMP, S_SQR, S_RINIT, S_ROOT, S_LOAD,
		S_ITER, S_DEG, S_CONV, S_WRAP, S_HEAD, S_HEADW, S_FIN
	} state_t;

	typedef enum logic [1:0] {PH_ROLL, PH_PITCH, PH_YAW} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic [3:0] k_q;

	// latched sample
	logic signed [15:0] qr_q, qi_q, qj_q, qk_q;

	// product sums: roll y, roll squares, sine, yaw y, yaw squares
	logic signed [SUM_W-1:0] ry_r_q, sq_r_q, s_q, ry_w_q, sq_w_q;
	// clamped sine in q30, plus or minus one included
	logic signed [31:0] s30_q;

	// square root unit
	logic [61:0] rn_q, rres_q;
	logic [60:0] rbit_q;

	// cordic unit
	logic signed [CORDIC_W-1:0] cx_q, cy_q;
	logic [31:0] cacc_q;
	logic czero_q;
	logic [4:0] it_q;

	// shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p, prod_q;

	// block state
	logic signed [16:0] raw_yaw_q, yaw_offset_q, held_roll_q, yaw_q;
	logic signed [15:0] held_pitch_q, head_q;
	logic zev_q;

	// output register
	logic out_valid_q, out_zev_q;
	logic signed [16:0] out_roll_q, out_yaw_q;
	logic signed [15:0] out_pitch_q, out_head_q;

	logic [3:0] kp;
	logic signed [SUM_W-1:0] p_sum;
	logic signed [CORDIC_W-1:0] ld_x, ld_y, dx, dy;
	logic signed [33:0] s2, sc;
	logic [61:0] rtry;
	logic signed [63:0] deg_full, head_full;
	logic signed [16:0] deg17;
	logic signed [17:0] ydiff;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_PROD: begin
				case (k_q)
					4'd0: begin mul_a = 32'(qr_q); mul_b = 32'(qi_q); end
					4'd1: begin mul_a = 32'(qj_q); mul_b = 32'(qk_q); end
					4'd2: begin mul_a = 32'(qi_q); mul_b = 32'(qi_q); end
					4'd3: begin mul_a = 32'(qj_q); mul_b = 32'(qj_q); end
					4'd4: begin mul_a = 32'(qk_q); mul_b = 32'(qk_q); end
					4'd5: begin mul_a = 32'(qr_q); mul_b = 32'(qj_q); end
					4'd6: begin mul_a = 32'(qk_q); mul_b = 32'(qi_q); end
					4'd7: begin mul_a = 32'(qr_q); mul_b = 32'(qk_q); end
					4'd8: begin mul_a = 32'(qi_q); mul_b = 32'(qj_q); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_SQR: begin
				mul_a = s30_q;
				mul_b = s30_q;
			end
			S_DEG: begin
				mul_a = czero_q ? 32'sd0 : $signed(cacc_q);
				mul_b = DEG_PER_TURN;
			end
			S_HEAD: begin
				mul_a = 32'(yaw_q);
				mul_b = RAD_PER_DEG_Q32;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// products are at most 2^30 in size, so the low bits carry them whole
	assign kp    = k_q - 4'd1;
	assign p_sum = prod_q[SUM_W-1:0];

	// cordic load vector per angle
	always_comb begin
		case (phase_q)
			PH_ROLL: begin
				ld_y = CORDIC_W'(ry_r_q) <<< 1;
				ld_x = ONE_Q - (CORDIC_W'(sq_r_q) <<< 1);
			end
			PH_PITCH: begin
				ld_y = CORDIC_W'(s30_q);
				ld_x = CORDIC_W'($signed({1'b0, rres_q[30:0]}));
			end
			PH_YAW: begin
				ld_y = CORDIC_W'(ry_w_q) <<< 1;
				ld_x = ONE_Q - (CORDIC_W'(sq_w_q) <<< 1);
			end
			default: begin
				ld_y = '0;
				ld_x = '0;
			end
		endcase
	end

	// floor shifts of the rotation
	assign dx = cy_q >>> it_q;
	assign dy = cx_q >>> it_q;

	// sine clamp to plus or minus one
	assign s2 = 34'(s_q) <<< 1;
	always_comb begin
		if (s2 > SIN_MAX)
			sc = SIN_MAX;
		else if (s2 < -SIN_MAX)
			sc = -SIN_MAX;
		else
			sc = s2;
	end

	assign rtry      = rres_q + 62'(rbit_q);
	assign deg_full  = prod_q + (64'sd1 <<< 31);
	assign deg17     = deg_full[48:32];
	assign head_full = prod_q + (64'sd1 <<< (HEAD_SHIFT - 1));
	assign ydiff     = 18'(raw_yaw_q) - 18'(yaw_offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_ROLL;
			k_q          <= '0;
			qr_q         <= '0;
			qi_q         <= '0;
			qj_q         <= '0;
			qk_q         <= '0;
			ry_r_q       <= '0;
			sq_r_q       <= '0;
			s_q          <= '0;
			ry_w_q       <= '0;
			sq_w_q       <= '0;
			s30_q        <= '0;
			rn_q         <= '0;
			rres_q       <= '0;
			rbit_q       <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			cacc_q       <= '0;
			czero_q      <= 1'b0;
			it_q         <= '0;
			prod_q       <= '0;
			raw_yaw_q    <= '0;
			yaw_offset_q <= '0;
			held_roll_q  <= '0;
			held_pitch_q <= '0;
			yaw_q        <= '0;
			head_q       <= '0;
			zev_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_zev_q    <= 1'b0;
			out_roll_q   <= '0;
			out_pitch_q  <= '0;
			out_yaw_q    <= '0;
			out_head_q   <= '0;
		end else begin
			prod_q <= mul_p;

			// result taken downstream, unless a new one replaces it this cycle
			if (out_valid_q && !out_stall && state_q != S_FIN)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (mode) begin
							// zero event: last raw yaw becomes the offset
							yaw_offset_q <= raw_yaw_q;
							yaw_q        <= '0;
							head_q       <= '0;
							zev_q        <= 1'b1;
							state_q      <= S_FIN;
						end else begin
							qr_q    <= quat_real;
							qi_q    <= quat_i;
							qj_q    <= quat_j;
							qk_q    <= quat_k;
							ry_r_q  <= '0;
							sq_r_q  <= '0;
							s_q     <= '0;
							ry_w_q  <= '0;
							sq_w_q  <= '0;
							k_q     <= '0;
							zev_q   <= 1'b0;
							state_q <= S_PROD;
						end
					end
				end
				S_PROD: begin
					// product of the previous step lands in its sum
					if (k_q != 4'd0) begin
						case (kp)
							4'd0, 4'd1: ry_r_q <= ry_r_q + p_sum;
							4'd2: sq_r_q <= sq_r_q + p_sum;
							4'd3: begin
								sq_r_q <= sq_r_q + p_sum;
								sq_w_q <= sq_w_q + p_sum;
							end
							4'd4: sq_w_q <= sq_w_q + p_sum;
							4'd5: s_q <= s_q + p_sum;
							4'd6: s_q <= s_q - p_sum;
							4'd7, 4'd8: ry_w_q <= ry_w_q + p_sum;
							default: ;
						endcase
					end
					if (k_q == 4'd9)
						state_q <= S_CLAMP;
					else
						k_q <= k_q + 4'd1;
				end
				S_CLAMP: begin
					s30_q   <= 32'(sc <<< S30_SHIFT);
					state_q <= S_SQR;
				end
				S_SQR: begin
					state_q <= S_RINIT;
				end
				S_RINIT: begin
					rn_q    <= (62'd1 << 60) - 62'(prod_q[61:0]);
					rres_q  <= '0;
					rbit_q  <= 61'd1 << 60;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rn_q >= rtry) begin
						rn_q   <= rn_q - rtry;
						rres_q <= (rres_q >> 1) + 62'(rbit_q);
					end else begin
						rres_q <= rres_q >> 1;
					end
					rbit_q <= rbit_q >> 2;
					if (rbit_q[0]) begin
						phase_q <= PH_ROLL;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					czero_q <= (ld_x == '0) && (ld_y == '0);
					it_q    <= '0;
					if (ld_x < 0) begin
						if (ld_y >= 0) begin
							cx_q   <= ld_y;
							cy_q   <= -ld_x;
							cacc_q <= BAM_QUARTER;
						end else begin
							cx_q   <= -ld_y;
							cy_q   <= ld_x;
							cacc_q <= BAM_NQUARTER;
						end
					end else begin
						cx_q   <= ld_x;
						cy_q   <= ld_y;
						cacc_q <= '0;
					end
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (cy_q > 0) begin
						cx_q   <= cx_q + dx;
						cy_q   <= cy_q - dy;
						cacc_q <= cacc_q + atan_bam(it_q);
					end else begin
						cx_q   <= cx_q - dx;
						cy_q   <= cy_q + dy;
						cacc_q <= cacc_q - atan_bam(it_q);
					end
					if (it_q == STEP_LAST)
						state_q <= S_DEG;
					else
						it_q <= it_q + 5'd1;
				end
				S_DEG: begin
					state_q <= S_CONV;
				end
				S_CONV: begin
					case (phase_q)
						PH_ROLL: begin
							held_roll_q <= deg17;
							phase_q     <= PH_PITCH;
							state_q     <= S_LOAD;
						end
						PH_PITCH: begin
							if (deg17 > QUARTER_TURN)
								held_pitch_q <= 16'(QUARTER_TURN);
							else if (deg17 < -QUARTER_TURN)
								held_pitch_q <= 16'(-QUARTER_TURN);
							else
								held_pitch_q <= 16'(deg17);
							phase_q <= PH_YAW;
							state_q <= S_LOAD;
						end
						default: begin
							raw_yaw_q <= deg17;
							state_q   <= S_WRAP;
						end
					endcase
				end
				S_WRAP: begin
					if (ydiff >= HALF_TURN)
						yaw_q <= 17'(ydiff - (HALF_TURN <<< 1));
					else if (ydiff < -HALF_TURN)
						yaw_q <= 17'(ydiff + (HALF_TURN <<< 1));
					else
						yaw_q <= 17'(ydiff);
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					state_q <= S_HEADW;
				end
				S_HEADW: begin
					head_q  <= head_full[HEAD_SHIFT+15:HEAD_SHIFT];
					state_q <= S_FIN;
				end
				S_FIN: begin
					// wait for the output register to free up
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_roll_q  <= held_roll_q;
						out_pitch_q <= held_pitch_q;
						out_yaw_q   <= yaw_q;
						out_head_q  <= head_q;
						out_zev_q   <= zev_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign roll_deg        = out_roll_q;
	assign pitch_deg       = out_pitch_q;
	assign yaw_deg         = out_yaw_q;
	assign heading_rad     = out_head_q;
	assign from_zero_event = out_zev_q;

`include "quaternion_to_euler_with_yaw_zero_macros.svh"

	// an accepted item makes the block busy in the next cycle
	`QTE_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "block not busy after transfer")
	// zero event reports zero yaw and heading
	`QTE_ASSERT_NOW(a_zero_event_yaw, out_valid && from_zero_event, (yaw_deg == 17'sd0) && (heading_rad == 16'sd0), "zero event with nonzero yaw")
	// pitch stays within plus or minus ninety degrees
	`QTE_ASSERT_NOW(a_pitch_range, out_valid, (pitch_deg <= 16'sd23040) && (pitch_deg >= -16'sd23040), "pitch out of range")
	// wrapped yaw lies in the half-open turn
	`QTE_ASSERT_NOW(a_yaw_range, out_valid, (yaw_deg < 17'sd46080) && (yaw_deg >= -17'sd46080), "yaw out of range")

endmodule
